// ----- hw/rtl/gn3_pkg.sv -----
// Shared types and constants of the 3-D gradient noise core.
package gn3_pkg;

   localparam int TableSize  = 256;
   localparam int IndexWidth = 8;
   localparam int CoordWidth = 32;
   localparam int NoiseWidth = 19;
   localparam int OutFrac    = 16;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_EVAL = 1'b1
   } op_type;

   // Gradient selector codes.
   localparam logic [3:0] HashUseY  = 4'd8;
   localparam logic [3:0] HashVY    = 4'd4;
   localparam logic [3:0] HashVXLo  = 4'd12;
   localparam logic [3:0] HashVXHi  = 4'd14;

endpackage

// ----- hw/rtl/gradient_noise_3d_core.sv -----
// 3-D gradient noise core: permutation table memories and the blend pipeline.
//
// A word on the request channel is taken at a clock edge where start is high and
// busy is low; busy is high only while reset is held, so one word may be issued every
// cycle. A load
// word (req_op low) writes req_table_value into permutation entry req_table_index
// and gives no result. An evaluate word (req_op high) takes req_coord_x/y/z in
// signed fixed point with FRACTION_BITS fraction bits and gives one noise word
// from the last stage, shown on rsp_noise_value for one cycle with rsp_valid high.
// Throughput is one word per cycle. The table is held in seven copies, one per
// hash level read port pair; a load word travels down the first three stages and
// writes each copy as it passes, so every evaluate word sees the table exactly as
// the words before it left it. The fade and blend multipliers are pipelined one
// per stage. Reset clears the pipeline; table contents are undefined until loaded.
// The receiver cannot stall: every result word is taken in the cycle it is shown.
module gradient_noise_3d_core #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        start,
   output logic                                        busy,
   input  logic                                        req_op,
   input  logic [gn3_pkg::IndexWidth-1:0]              req_table_index,
   input  logic [gn3_pkg::IndexWidth-1:0]              req_table_value,
   input  logic signed [gn3_pkg::CoordWidth-1:0]       req_coord_x,
   input  logic signed [gn3_pkg::CoordWidth-1:0]       req_coord_y,
   input  logic signed [gn3_pkg::CoordWidth-1:0]       req_coord_z,
   output logic                                        rsp_valid,
   output logic signed [gn3_pkg::NoiseWidth-1:0]       rsp_noise_value
);
   import gn3_pkg::*;

   localparam int F   = FRACTION_BITS;
   localparam int GW  = F + 3;
   localparam int ShR = (F > OutFrac) ? F - OutFrac : 0;
   localparam int ShL = (F < OutFrac) ? OutFrac - F : 0;
   localparam logic [F+1:0] ThreeOne = (F+2)'(3) << F;
   localparam logic signed [GW-1:0] OneG = GW'(1) << F;

   typedef logic [IndexWidth-1:0] idx_type;
   typedef logic [F-1:0]          frac_type;
   typedef logic [F:0]            fade_type;
   typedef logic signed [GW-1:0]  val_type;

   function automatic val_type grad_fn(input logic [3:0] h, input val_type x,
                                       input val_type y, input val_type z);
      val_type u, v, su, sv;
      u  = (h < HashUseY) ? x : y;
      v  = (h < HashVY) ? y : ((h == HashVXLo || h == HashVXHi) ? x : z);
      su = h[0] ? -u : u;
      sv = h[1] ? -v : v;
      return su + sv;
   endfunction

   function automatic val_type lerp_fn(input val_type a, input val_type b,
                                       input fade_type t);
      logic signed [GW:0]      d;
      logic signed [GW+F+1:0]  p;
      d = (GW+1)'(b) - (GW+1)'(a);
      p = (GW+F+2)'(d) * $signed((GW+F+2)'(t));
      return a + GW'(p >>> F);
   endfunction

   logic acc, load0, eval0;
   assign busy  = reset;
   assign acc   = start & ~busy;
   assign load0 = acc & (req_op == OP_LOAD);
   assign eval0 = acc & (req_op == OP_EVAL);

   // Stage 0: lattice cell and first hash level.
   idx_type  cx, cy, cz;
   frac_type fr0 [3];
   assign cx = req_coord_x[F +: IndexWidth];
   assign cy = req_coord_y[F +: IndexWidth];
   assign cz = req_coord_z[F +: IndexWidth];
   assign fr0[0] = req_coord_x[F-1:0];
   assign fr0[1] = req_coord_y[F-1:0];
   assign fr0[2] = req_coord_z[F-1:0];

   logic [IndexWidth-1:0] mem0 [TableSize];
   idx_type rd0a_ff, rd0b_ff;
   always_ff @(posedge clock) begin
      if (load0) begin
         mem0[req_table_index] <= req_table_value;
      end
      rd0a_ff <= mem0[cx];
      rd0b_ff <= mem0[cx + idx_type'(1)];
   end

   logic     ld1_ff, ev1_ff;
   idx_type  idx1_ff, val1_ff, cy1_ff, cz1_ff;
   frac_type fr1_ff [3];
   always_ff @(posedge clock) begin
      if (reset) begin
         ld1_ff <= 1'b0;
         ev1_ff <= 1'b0;
      end else begin
         ld1_ff <= load0;
         ev1_ff <= eval0;
      end
      idx1_ff <= req_table_index;
      val1_ff <= req_table_value;
      cy1_ff  <= cy;
      cz1_ff  <= cz;
      fr1_ff  <= fr0;
   end

   // Stage 1: second hash level, square of the fractions.
   idx_type a_in, b_in;
   assign a_in = rd0a_ff + cy1_ff;
   assign b_in = rd0b_ff + cy1_ff;

   logic [IndexWidth-1:0] mem1a [TableSize];
   logic [IndexWidth-1:0] mem1b [TableSize];
   idx_type rd1a0_ff, rd1a1_ff, rd1b0_ff, rd1b1_ff;
   always_ff @(posedge clock) begin
      if (ld1_ff) begin
         mem1a[idx1_ff] <= val1_ff;
      end
      rd1a0_ff <= mem1a[a_in];
      rd1a1_ff <= mem1a[a_in + idx_type'(1)];
   end
   always_ff @(posedge clock) begin
      if (ld1_ff) begin
         mem1b[idx1_ff] <= val1_ff;
      end
      rd1b0_ff <= mem1b[b_in];
      rd1b1_ff <= mem1b[b_in + idx_type'(1)];
   end

   frac_type sq_in [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic [2*F-1:0] p;
         p = (2*F)'(fr1_ff[i]) * (2*F)'(fr1_ff[i]);
         sq_in[i] = p[2*F-1:F];
      end
   end

   logic     ld2_ff, ev2_ff;
   idx_type  idx2_ff, val2_ff, cz2_ff;
   frac_type fr2_ff [3];
   frac_type sq2_ff [3];
   always_ff @(posedge clock) begin
      if (reset) begin
         ld2_ff <= 1'b0;
         ev2_ff <= 1'b0;
      end else begin
         ld2_ff <= ld1_ff;
         ev2_ff <= ev1_ff;
      end
      idx2_ff <= idx1_ff;
      val2_ff <= val1_ff;
      cz2_ff  <= cz1_ff;
      fr2_ff  <= fr1_ff;
      sq2_ff  <= sq_in;
   end

   // Stage 2: corner hashes, fade curve.
   idx_type aa_in, ab_in, ba_in, bb_in;
   assign aa_in = rd1a0_ff + cz2_ff;
   assign ab_in = rd1a1_ff + cz2_ff;
   assign ba_in = rd1b0_ff + cz2_ff;
   assign bb_in = rd1b1_ff + cz2_ff;

   logic [IndexWidth-1:0] mem2a [TableSize];
   logic [IndexWidth-1:0] mem2b [TableSize];
   logic [IndexWidth-1:0] mem2c [TableSize];
   logic [IndexWidth-1:0] mem2d [TableSize];
   idx_type h_ff [8];
   always_ff @(posedge clock) begin
      if (ld2_ff) begin
         mem2a[idx2_ff] <= val2_ff;
      end
      h_ff[0] <= mem2a[aa_in];
      h_ff[4] <= mem2a[aa_in + idx_type'(1)];
   end
   always_ff @(posedge clock) begin
      if (ld2_ff) begin
         mem2b[idx2_ff] <= val2_ff;
      end
      h_ff[2] <= mem2b[ab_in];
      h_ff[6] <= mem2b[ab_in + idx_type'(1)];
   end
   always_ff @(posedge clock) begin
      if (ld2_ff) begin
         mem2c[idx2_ff] <= val2_ff;
      end
      h_ff[1] <= mem2c[ba_in];
      h_ff[5] <= mem2c[ba_in + idx_type'(1)];
   end
   always_ff @(posedge clock) begin
      if (ld2_ff) begin
         mem2d[idx2_ff] <= val2_ff;
      end
      h_ff[3] <= mem2d[bb_in];
      h_ff[7] <= mem2d[bb_in + idx_type'(1)];
   end

   fade_type fade_in [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic [F+1:0]   k;
         logic [2*F+1:0] p;
         k = ThreeOne - {1'b0, fr2_ff[i], 1'b0};
         p = (2*F+2)'(sq2_ff[i]) * (2*F+2)'(k);
         fade_in[i] = p[2*F:F];
      end
   end

   logic     ev3_ff;
   frac_type fr3_ff [3];
   fade_type fd3_ff [3];
   always_ff @(posedge clock) begin
      if (reset) begin
         ev3_ff <= 1'b0;
      end else begin
         ev3_ff <= ev2_ff;
      end
      fr3_ff <= fr2_ff;
      fd3_ff <= fade_in;
   end

   // Stage 3: corner gradients. Corner k has bit 0 for x, bit 1 for y, bit 2 for z.
   val_type g_in [8];
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         val_type p [3];
         for (int i = 0; i < 3; i++) begin
            p[i] = GW'(fr3_ff[i]);
            if (k[i]) begin
               p[i] = GW'(fr3_ff[i]) - OneG;
            end
         end
         g_in[k] = grad_fn(h_ff[k][3:0], p[0], p[1], p[2]);
      end
   end

   logic     ev4_ff;
   val_type  g4_ff [8];
   fade_type fd4_ff [3];
   always_ff @(posedge clock) begin
      if (reset) begin
         ev4_ff <= 1'b0;
      end else begin
         ev4_ff <= ev3_ff;
      end
      g4_ff  <= g_in;
      fd4_ff <= fd3_ff;
   end

   // Stage 4: blend along x.
   val_type l_in [4];
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         l_in[j] = lerp_fn(g4_ff[2*j], g4_ff[2*j+1], fd4_ff[0]);
      end
   end

   logic     ev5_ff;
   val_type  l5_ff [4];
   fade_type fd5_ff [3];
   always_ff @(posedge clock) begin
      if (reset) begin
         ev5_ff <= 1'b0;
      end else begin
         ev5_ff <= ev4_ff;
      end
      l5_ff  <= l_in;
      fd5_ff <= fd4_ff;
   end

   // Stage 5: blend along y.
   val_type m0_in, m1_in;
   assign m0_in = lerp_fn(l5_ff[0], l5_ff[1], fd5_ff[1]);
   assign m1_in = lerp_fn(l5_ff[2], l5_ff[3], fd5_ff[1]);

   logic     ev6_ff;
   val_type  m0_ff, m1_ff;
   fade_type fd6_ff [3];
   always_ff @(posedge clock) begin
      if (reset) begin
         ev6_ff <= 1'b0;
      end else begin
         ev6_ff <= ev5_ff;
      end
      m0_ff  <= m0_in;
      m1_ff  <= m1_in;
      fd6_ff <= fd5_ff;
   end

   // Stage 6: blend along z and rescale to the output fraction width.
   val_type r_in;
   logic signed [NoiseWidth+GW-1:0] wide_in;
   logic signed [NoiseWidth-1:0]    noise_in;
   assign r_in     = lerp_fn(m0_ff, m1_ff, fd6_ff[2]);
   assign wide_in  = ((NoiseWidth+GW)'(r_in) >>> ShR) <<< ShL;
   assign noise_in = wide_in[NoiseWidth-1:0];

   logic                          rsp_valid_ff;
   logic signed [NoiseWidth-1:0]  rsp_noise_value_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ev6_ff;
      end
      rsp_noise_value_ff <= noise_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_noise_value_ff;

endmodule

// ----- hw/rtl/gn3_checker.sv -----
// Port-level checks of the 3-D gradient noise core and their binding.
module gn3_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  start,
   input logic                                  busy,
   input logic                                  req_op,
   input logic                                  rsp_valid,
   input logic signed [gn3_pkg::NoiseWidth-1:0] rsp_noise_value
);
   import gn3_pkg::*;

   localparam int NoiseLimit = 2 << OutFrac;

   logic take;
   assign take = start & ~busy;

   // An evaluate word always yields a result word.
   a_eval_result: assert property (@(posedge clock) disable iff (reset)
      (take && req_op == OP_EVAL) |-> ##7 rsp_valid)
      else $error("evaluate word gave no result");

   // A load word never yields a result.
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (take && req_op == OP_LOAD) |-> ##7 !rsp_valid)
      else $error("load word gave a result");

   // The core takes a word every cycle.
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("core raised busy");

   // Reset flushes the pipeline.
   a_reset_flush: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word right after reset");

   // Noise stays within plus or minus two.
   a_noise_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_noise_value >= -NoiseLimit && rsp_noise_value <= NoiseLimit))
      else $error("noise word out of range");

endmodule

bind gradient_noise_3d_core gn3_checker u_gn3_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .req_op(req_op),
   .rsp_valid(rsp_valid),
   .rsp_noise_value(rsp_noise_value)
);

// ----- tb/gradient_noise_3d_checker.sv -----
// Checker for the gradient noise core: watches request and result words and compares noise.
module gradient_noise_3d_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic                                  busy,
   input  logic                                  req_op,
   input  logic [gn3_pkg::IndexWidth-1:0]        req_table_index,
   input  logic [gn3_pkg::IndexWidth-1:0]        req_table_value,
   input  logic signed [gn3_pkg::CoordWidth-1:0] req_coord_x,
   input  logic signed [gn3_pkg::CoordWidth-1:0] req_coord_y,
   input  logic signed [gn3_pkg::CoordWidth-1:0] req_coord_z,
   input  logic                                  rsp_valid,
   input  logic signed [gn3_pkg::NoiseWidth-1:0] rsp_noise_value,
   output int                                    fail_count,
   output int                                    pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import gn3_pkg::*;

   localparam int Frac = 16;
   localparam longint One = longint'(1) << Frac;

   logic [7:0] perm_copy [TableSize];
   logic signed [NoiseWidth-1:0] expected_noise [$];

   function automatic longint fade_curve(longint f);
      longint sq;
      sq = (f * f) >>> Frac;
      return (sq * (3 * One - 2 * f)) >>> Frac;
   endfunction

   function automatic longint mix(longint a, longint b, longint t);
      return a + ((t * (b - a)) >>> Frac);
   endfunction

   function automatic longint corner_gradient(logic [7:0] hash, longint x, longint y,
                                              longint z);
      logic [3:0] h;
      longint u;
      longint v;
      h = hash[3:0];
      u = (h < HashUseY) ? x : y;
      v = (h < HashVY) ? y : ((h == HashVXLo || h == HashVXHi) ? x : z);
      return (h[0] ? -u : u) + (h[1] ? -v : v);
   endfunction

   function automatic logic [7:0] lookup(logic [7:0] idx);
      return perm_copy[idx];
   endfunction

   function automatic logic signed [NoiseWidth-1:0] noise_at(logic [31:0] rx, logic [31:0] ry,
                                                             logic [31:0] rz);
      logic [7:0] cx, cy, cz, a, aa, ab, b, ba, bb;
      longint fx, fy, fz, gx, gy, gz, u, v, w, l00, l10, l01, l11, m0, m1;
      cx = rx[Frac +: 8];
      cy = ry[Frac +: 8];
      cz = rz[Frac +: 8];
      fx = longint'(rx[Frac-1:0]);
      fy = longint'(ry[Frac-1:0]);
      fz = longint'(rz[Frac-1:0]);
      gx = fx - One;
      gy = fy - One;
      gz = fz - One;
      u = fade_curve(fx);
      v = fade_curve(fy);
      w = fade_curve(fz);
      a = lookup(cx) + cy;
      aa = lookup(a) + cz;
      ab = lookup(a + 8'd1) + cz;
      b = lookup(cx + 8'd1) + cy;
      ba = lookup(b) + cz;
      bb = lookup(b + 8'd1) + cz;
      l00 = mix(corner_gradient(lookup(aa), fx, fy, fz),
                corner_gradient(lookup(ba), gx, fy, fz), u);
      l10 = mix(corner_gradient(lookup(ab), fx, gy, fz),
                corner_gradient(lookup(bb), gx, gy, fz), u);
      l01 = mix(corner_gradient(lookup(aa + 8'd1), fx, fy, gz),
                corner_gradient(lookup(ba + 8'd1), gx, fy, gz), u);
      l11 = mix(corner_gradient(lookup(ab + 8'd1), fx, gy, gz),
                corner_gradient(lookup(bb + 8'd1), gx, gy, gz), u);
      m0 = mix(l00, l10, v);
      m1 = mix(l01, l11, v);
      return NoiseWidth'(mix(m0, m1, w));
   endfunction

   initial begin
      fail_count = 0;
      pending_count = 0;
      for (int i = 0; i < TableSize; i++) perm_copy[i] = '0;
   end

   // The result is checked before the request of the same edge is predicted, which is
   // harmless since a result never comes back in the cycle its word was issued.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_noise.size() == 0) begin
               if (fail_count < 10) $display("unexpected noise word %0d", rsp_noise_value);
               fail_count++;
            end else begin
               logic signed [NoiseWidth-1:0] want;
               want = expected_noise.pop_front();
               if (want !== rsp_noise_value) begin
                  if (fail_count < 10)
                     $display("noise mismatch: expected %0d got %0d", want, rsp_noise_value);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            if (op_type'(req_op) == OP_LOAD) perm_copy[req_table_index] = req_table_value;
            else expected_noise = {expected_noise,
                                   noise_at(req_coord_x, req_coord_y, req_coord_z)};
         end
         pending_count = expected_noise.size();
      end
   end
endmodule

// ----- tb/gradient_noise_3d_core_test.sv -----
// Top of the gradient noise testbench: clock, reset, stimulus and verdict.
module gradient_noise_3d_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import gn3_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic req_op = OP_EVAL;
   logic [IndexWidth-1:0] req_table_index = '0;
   logic [IndexWidth-1:0] req_table_value = '0;
   logic signed [CoordWidth-1:0] req_coord_x = '0;
   logic signed [CoordWidth-1:0] req_coord_y = '0;
   logic signed [CoordWidth-1:0] req_coord_z = '0;
   logic rsp_valid;
   logic signed [NoiseWidth-1:0] rsp_noise_value;
   int fail_count;
   int pending_count;
   bit quiet_tail = 0;

   always #5 clock = ~clock;

   gradient_noise_3d_core uut (.*);
   gradient_noise_3d_checker watch (.*);

   // Issues one word at the falling edge, holds it until taken, maybe idles after.
   task automatic issue(op_type op, logic [7:0] idx, logic [7:0] val,
                        logic [31:0] x, logic [31:0] y, logic [31:0] z);
      req_op <= op;
      req_table_index <= idx;
      req_table_value <= val;
      req_coord_x <= x;
      req_coord_y <= y;
      req_coord_z <= z;
      start <= 1;
      do @(posedge clock); while (busy);
      @(negedge clock);
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         start <= 0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
   endtask

   task automatic eval_at(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      issue(OP_EVAL, 8'($urandom), 8'($urandom), x, y, z);
   endtask

   task automatic fill_table(bit identity);
      for (int i = 0; i < TableSize; i++)
         issue(OP_LOAD, 8'(i), identity ? 8'(i) : 8'($urandom), $urandom, $urandom, $urandom);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      fill_table(1);
      eval_at(32'h0, 32'h0, 32'h0);
      eval_at(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      eval_at(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      eval_at(32'hFFFF_FFFF, 32'h0000_FFFF, 32'hFFFF_0000);
      eval_at(32'h0000_8000, 32'h0001_4000, 32'hFFFE_C000);
      for (int h = 0; h < 16; h++) begin
         issue(OP_LOAD, 8'd0, 8'(h), '0, '0, '0);
         eval_at(32'h0000_6000, 32'h0000_A000, 32'h0000_3000);
      end
      fill_table(0);
      for (int n = 0; n < 400; n++) begin
         if (n > 320) quiet_tail = 1;
         if ($urandom_range(0, 9) == 0)
            issue(OP_LOAD, 8'($urandom), 8'($urandom), $urandom, $urandom, $urandom);
         else
            eval_at($urandom, $urandom, $urandom);
      end
      start <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #2ms;
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule
